[rtl/ptli_pkg.sv]
// Shared types and constants for the profile table interpolator.
`timescale 1ns / 1ps
package ptli_pkg;

    localparam int VAL_W     = 32;
    localparam int NUM_VALS  = 4;
    localparam int ROW_W     = VAL_W * (NUM_VALS + 1);
    localparam int CNT_W     = 7;
    localparam int ROWIDX_W  = 6;
    localparam int SEG_W     = 6;
    localparam int FRAC_W    = 17;
    localparam int STATUS_W  = 3;
    localparam int S_DATA_W  = 168;
    localparam int M_DATA_W  = 152;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_LOADED    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_INTERIOR  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_CLAMP_LO  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_CLAMP_HI  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOT_READY = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CHK_FIRST,
        S_CHK_LAST,
        S_SCAN,
        S_RD_K,
        S_RD_K1,
        S_DIV_INIT,
        S_DIV,
        S_MUL,
        S_FIN
    } state_t;

    typedef enum logic [2:0] {
        RD_ZERO,
        RD_LAST,
        RD_IDX,
        RD_K,
        RD_K1
    } rd_sel_t;

    typedef struct packed {
        logic    capture;
        logic    mem_write;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    set_load;
        logic    set_not_ready;
        logic    set_clamp_lo;
        logic    set_clamp_hi;
        logic    k_clear;
        logic    scan_cmp;
        logic    latch_a;
        logic    div_init;
        logic    div_step;
        logic    set_interior;
        logic    mul_en;
        logic [1:0] mul_lane;
        logic    fin_en;
        logic [1:0] fin_lane;
        logic    out_load;
    } cmd_base_t;

    typedef struct packed {
        logic is_load;
        logic le_rd;
        logic ge_rd;
        logic out_free;
    } stat_base_t;

endpackage

[rtl/ptli_datapath.sv]
// Datapath: row memory, segment compare, fraction divider, shared multiplier, output register.
`timescale 1ns / 1ps
module ptli_datapath #(
    parameter int MAX_ROWS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [ptli_pkg::CNT_W-1:0]           cfg_wr_data,
    input  logic [ptli_pkg::S_DATA_W-1:0]        s_tdata,
    input  logic                                 s_tuser,
    input  ptli_pkg::cmd_base_t                  cmd,
    input  logic [$clog2(MAX_ROWS)-1:0]          cmd_idx,
    output ptli_pkg::stat_base_t                 stat,
    output logic [$clog2(MAX_ROWS+1)-1:0]        stat_n,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ptli_pkg::M_DATA_W-1:0]        m_tdata,
    output logic [ptli_pkg::STATUS_W-1:0]        m_tuser
);
    localparam int AW  = $clog2(MAX_ROWS);
    localparam int NW  = $clog2(MAX_ROWS + 1);
    localparam int CW  = (NW > ptli_pkg::CNT_W) ? NW : ptli_pkg::CNT_W;
    localparam int RW  = ((AW > ptli_pkg::ROWIDX_W) ? AW : ptli_pkg::ROWIDX_W) + 1;
    localparam int SGW = (AW > ptli_pkg::SEG_W) ? AW : ptli_pkg::SEG_W;
    localparam int FW  = (FRAC_BITS > ptli_pkg::FRAC_W) ? FRAC_BITS : ptli_pkg::FRAC_W;
    localparam int PW  = ptli_pkg::VAL_W + 1 + FRAC_BITS + 1;
    localparam int VW  = ptli_pkg::VAL_W;

    logic [ptli_pkg::CNT_W-1:0] count_reg;
    logic [ptli_pkg::ROW_W-1:0] mem [MAX_ROWS];
    logic [ptli_pkg::ROW_W-1:0] rd_reg;
    logic [ptli_pkg::ROW_W-1:0] row_a_reg, row_b_reg;
    logic                        op_reg;
    logic [ptli_pkg::ROWIDX_W-1:0] row_idx_reg;
    logic [VW-1:0]               rad_reg;
    logic [4*VW-1:0]             vals_in_reg;
    logic [AW-1:0]               k_reg;
    logic [VW:0]                 rem_reg;
    logic [VW-1:0]               den_reg;
    logic [FRAC_BITS-1:0]        hx_reg;
    logic signed [PW-1:0]        prod_reg;
    logic [VW-1:0]               res_val_reg [ptli_pkg::NUM_VALS];
    logic [AW-1:0]               res_seg_reg;
    logic [FRAC_BITS-1:0]        res_hx_reg;
    logic [ptli_pkg::STATUS_W-1:0] res_stat_reg;
    logic                        m_tvalid_reg;
    logic [ptli_pkg::M_DATA_W-1:0] m_tdata_reg;
    logic [ptli_pkg::STATUS_W-1:0] m_tuser_reg;

    logic [CW-1:0]  count_wide;
    logic [NW-1:0]  n_val;
    logic [AW-1:0]  last_idx;
    logic [AW-1:0]  rd_addr;
    logic [RW-1:0]  row_wide;
    logic [VW:0]    div_shift;
    logic           div_ge;
    logic signed [VW:0] diff;
    logic [VW-1:0]  rd_rad;
    logic [SGW-1:0] seg_wide;
    logic [FW-1:0]  frac_wide;

    assign count_wide = CW'(count_reg);
    assign n_val = (count_wide > CW'(MAX_ROWS)) ? NW'(MAX_ROWS) : count_wide[NW-1:0];
    assign last_idx = AW'(n_val - NW'(1));
    assign row_wide = RW'(row_idx_reg);
    assign rd_rad = rd_reg[VW-1:0];

    always_comb begin
        unique case (cmd.rd_sel)
            ptli_pkg::RD_ZERO: rd_addr = '0;
            ptli_pkg::RD_LAST: rd_addr = last_idx;
            ptli_pkg::RD_IDX:  rd_addr = cmd_idx;
            ptli_pkg::RD_K:    rd_addr = k_reg;
            ptli_pkg::RD_K1:   rd_addr = k_reg + AW'(1);
            default:           rd_addr = '0;
        endcase
    end

    assign stat.is_load  = (op_reg == ptli_pkg::OP_LOAD);
    assign stat.le_rd    = (rad_reg <= rd_rad);
    assign stat.ge_rd    = (rad_reg >= rd_rad);
    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign stat_n        = n_val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_wr_en) begin
            count_reg <= cfg_wr_data;
        end
    end

    // row memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.mem_write && (row_wide < RW'(MAX_ROWS))) begin
            mem[row_wide[AW-1:0]] <= {vals_in_reg, rad_reg};
        end
        if (cmd.rd_en) begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg      <= s_tuser;
            row_idx_reg <= s_tdata[ptli_pkg::ROWIDX_W-1:0];
            rad_reg     <= s_tdata[ptli_pkg::ROWIDX_W +: VW];
            vals_in_reg <= s_tdata[ptli_pkg::ROWIDX_W+VW +: 4*VW];
        end
        // during the scan cmd_idx points one row past the row held in rd_reg
        if (cmd.k_clear) begin
            k_reg <= '0;
        end else if (cmd.scan_cmp && (rd_rad <= rad_reg)) begin
            k_reg <= cmd_idx - AW'(1);
        end
        if (cmd.latch_a) begin
            row_a_reg <= rd_reg;
        end
        if (cmd.div_init) begin
            row_b_reg <= rd_reg;
        end
    end

    // restoring divider, one quotient bit per cycle; remainder stays below divisor
    assign div_shift = {rem_reg[VW-1:0], 1'b0};
    assign div_ge = (div_shift >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_reg <= {1'b0, rad_reg - row_a_reg[VW-1:0]};
            den_reg <= rd_rad - row_a_reg[VW-1:0];
            hx_reg  <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= div_ge ? (div_shift - {1'b0, den_reg}) : div_shift;
            hx_reg  <= {hx_reg[FRAC_BITS-2:0], div_ge};
        end
    end

    assign diff = $signed({row_b_reg[VW*(cmd.mul_lane+1)+VW-1], row_b_reg[VW*(cmd.mul_lane+1) +: VW]})
                - $signed({row_a_reg[VW*(cmd.mul_lane+1)+VW-1], row_a_reg[VW*(cmd.mul_lane+1) +: VW]});

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= PW'(diff * $signed({1'b0, hx_reg}));
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.set_load || cmd.set_not_ready) begin
            for (int j = 0; j < ptli_pkg::NUM_VALS; j++) res_val_reg[j] <= '0;
            res_seg_reg  <= '0;
            res_hx_reg   <= '0;
            res_stat_reg <= cmd.set_load ? ptli_pkg::STAT_LOADED : ptli_pkg::STAT_NOT_READY;
        end else if (cmd.set_clamp_lo || cmd.set_clamp_hi) begin
            for (int j = 0; j < ptli_pkg::NUM_VALS; j++) res_val_reg[j] <= rd_reg[VW*(j+1) +: VW];
            res_seg_reg  <= cmd.set_clamp_lo ? '0 : last_idx;
            res_hx_reg   <= '0;
            res_stat_reg <= cmd.set_clamp_lo ? ptli_pkg::STAT_CLAMP_LO : ptli_pkg::STAT_CLAMP_HI;
        end else begin
            if (cmd.set_interior) begin
                res_seg_reg  <= k_reg;
                res_hx_reg   <= hx_reg;
                res_stat_reg <= ptli_pkg::STAT_INTERIOR;
            end
            if (cmd.fin_en) begin
                // low word of a + (prod >>> FRAC_BITS)
                res_val_reg[cmd.fin_lane] <= row_a_reg[VW*(cmd.fin_lane+1) +: VW]
                                           + prod_reg[FRAC_BITS +: VW];
            end
        end
    end

    assign seg_wide  = SGW'(res_seg_reg);
    assign frac_wide = FW'(res_hx_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {1'b0, frac_wide[ptli_pkg::FRAC_W-1:0], seg_wide[ptli_pkg::SEG_W-1:0],
                            res_val_reg[3], res_val_reg[2], res_val_reg[1], res_val_reg[0]};
            m_tuser_reg <= res_stat_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[rtl/ptli_ctrl.sv]
// Controller state machine: sequences decode, search, division and multiply lanes.
`timescale 1ns / 1ps
module ptli_ctrl #(
    parameter int MAX_ROWS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  ptli_pkg::stat_base_t           stat,
    input  logic [$clog2(MAX_ROWS+1)-1:0]  stat_n,
    output ptli_pkg::cmd_base_t            cmd,
    output logic [$clog2(MAX_ROWS)-1:0]    cmd_idx
);
    localparam int AW = $clog2(MAX_ROWS);
    localparam int NW = $clog2(MAX_ROWS + 1);
    localparam int SW = $clog2(FRAC_BITS + 1);

    ptli_pkg::state_t state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [SW-1:0] step_reg, step_next;
    logic          scan_last;

    // scan covers rows 1..n-2
    assign scan_last = ((NW+1)'(idx_reg) + (NW+1)'(2)) >= (NW+1)'(stat_n);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ptli_pkg::S_IDLE;
            idx_reg   <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ptli_pkg::S_IDLE: begin
                if (s_tvalid) state_next = ptli_pkg::S_DECODE;
            end
            ptli_pkg::S_DECODE: begin
                if (stat.is_load || (stat_n < NW'(2))) state_next = ptli_pkg::S_FIN;
                else state_next = ptli_pkg::S_CHK_FIRST;
            end
            ptli_pkg::S_CHK_FIRST: begin
                state_next = stat.le_rd ? ptli_pkg::S_FIN : ptli_pkg::S_CHK_LAST;
            end
            ptli_pkg::S_CHK_LAST: begin
                idx_next = AW'(1);
                if (stat.ge_rd) state_next = ptli_pkg::S_FIN;
                else if (stat_n == NW'(2)) state_next = ptli_pkg::S_RD_K;
                else state_next = ptli_pkg::S_SCAN;
            end
            ptli_pkg::S_SCAN: begin
                if (scan_last) state_next = ptli_pkg::S_RD_K;
                else idx_next = idx_reg + AW'(1);
            end
            ptli_pkg::S_RD_K:  state_next = ptli_pkg::S_RD_K1;
            ptli_pkg::S_RD_K1: state_next = ptli_pkg::S_DIV_INIT;
            ptli_pkg::S_DIV_INIT: begin
                step_next  = '0;
                state_next = ptli_pkg::S_DIV;
            end
            ptli_pkg::S_DIV: begin
                if (step_reg == SW'(FRAC_BITS - 1)) begin
                    step_next  = '0;
                    state_next = ptli_pkg::S_MUL;
                end else begin
                    step_next = step_reg + SW'(1);
                end
            end
            ptli_pkg::S_MUL: begin
                if (step_reg == SW'(ptli_pkg::NUM_VALS)) state_next = ptli_pkg::S_FIN;
                else step_next = step_reg + SW'(1);
            end
            ptli_pkg::S_FIN: begin
                if (stat.out_free) state_next = ptli_pkg::S_IDLE;
            end
            default: state_next = ptli_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.rd_sel = ptli_pkg::RD_ZERO;
        cmd_idx  = idx_reg;
        s_tready = 1'b0;
        unique case (state_reg)
            ptli_pkg::S_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ptli_pkg::S_DECODE: begin
                cmd.mem_write     = stat.is_load;
                cmd.set_load      = stat.is_load;
                cmd.set_not_ready = !stat.is_load && (stat_n < NW'(2));
                cmd.rd_en         = 1'b1;
                cmd.rd_sel        = ptli_pkg::RD_ZERO;
            end
            ptli_pkg::S_CHK_FIRST: begin
                cmd.set_clamp_lo = stat.le_rd;
                cmd.rd_en        = 1'b1;
                cmd.rd_sel       = ptli_pkg::RD_LAST;
            end
            ptli_pkg::S_CHK_LAST: begin
                cmd.set_clamp_hi = stat.ge_rd;
                cmd.k_clear      = 1'b1;
                cmd.rd_en        = 1'b1;
                cmd.rd_sel       = ptli_pkg::RD_IDX;
                cmd_idx          = AW'(1);
            end
            ptli_pkg::S_SCAN: begin
                // row idx_reg is compared now, the row after it is fetched
                cmd.scan_cmp = 1'b1;
                cmd.rd_en    = !scan_last;
                cmd.rd_sel   = ptli_pkg::RD_IDX;
                cmd_idx      = idx_reg + AW'(1);
            end
            ptli_pkg::S_RD_K: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = ptli_pkg::RD_K;
            end
            ptli_pkg::S_RD_K1: begin
                cmd.latch_a = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = ptli_pkg::RD_K1;
            end
            ptli_pkg::S_DIV_INIT: cmd.div_init = 1'b1;
            ptli_pkg::S_DIV:      cmd.div_step = 1'b1;
            ptli_pkg::S_MUL: begin
                cmd.set_interior = (step_reg == '0);
                cmd.mul_en       = (step_reg < SW'(ptli_pkg::NUM_VALS));
                cmd.mul_lane     = step_reg[1:0];
                cmd.fin_en       = (step_reg != '0);
                cmd.fin_lane     = 2'(step_reg - SW'(1));
            end
            ptli_pkg::S_FIN: cmd.out_load = stat.out_free;
            default: ;
        endcase
    end

    // the scan starts at row one, so idx_reg is never zero in S_SCAN
    a_scan_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ptli_pkg::S_SCAN) |-> (idx_reg != '0))
        else $error("scan index at row zero");
    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ptli_pkg::S_DIV) |-> (step_reg < SW'(FRAC_BITS)))
        else $error("divider ran past fraction width");
    a_mul_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ptli_pkg::S_MUL) |-> (step_reg <= SW'(ptli_pkg::NUM_VALS)))
        else $error("lane counter overrun");

endmodule

[rtl/profile_table_linear_interp.sv]
// Top level: piecewise linear profile table with interpolated queries.
// Interior query time is set by the linear row scan over the single memory read port and
// the one-bit-per-cycle divider; loads, not-ready and clamped queries skip both.
// One transfer in flight; the next is taken the cycle after the result enters the output register.
// Synchronous active-low reset clears control and entry_count; table rows are not cleared.
`timescale 1ns / 1ps
module profile_table_linear_interp #(
    parameter int MAX_ROWS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [ptli_pkg::CNT_W-1:0]      cfg_wr_data,   // entry_count
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // row_index[5:0], radius, density_in, modulus_in, gravity_in, gradient_in, pad
    input  logic [ptli_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,       // opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // density_out, modulus_out, gravity_out, gradient_out, segment[5:0], fraction[16:0], pad
    output logic [ptli_pkg::M_DATA_W-1:0]   m_tdata,
    output logic [ptli_pkg::STATUS_W-1:0]   m_tuser        // status
);
    ptli_pkg::cmd_base_t                cmd;
    ptli_pkg::stat_base_t               stat;
    logic [$clog2(MAX_ROWS)-1:0]        cmd_idx;
    logic [$clog2(MAX_ROWS+1)-1:0]      stat_n;

    ptli_ctrl #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .stat(stat), .stat_n(stat_n), .cmd(cmd), .cmd_idx(cmd_idx)
    );

    ptli_datapath #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .cmd(cmd), .cmd_idx(cmd_idx),
        .stat(stat), .stat_n(stat_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= ptli_pkg::STAT_NOT_READY))
        else $error("bad status code");
    a_frac_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != ptli_pkg::STAT_INTERIOR)) |-> (m_tdata[150:134] == '0))
        else $error("fraction set outside interior result");
    a_empty_vals: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && ((m_tuser == ptli_pkg::STAT_LOADED) || (m_tuser == ptli_pkg::STAT_NOT_READY)))
        |-> (m_tdata[133:0] == '0))
        else $error("values set on load or not-ready result");

endmodule

[bench/testbench.sv]
// Self-checking bench for the profile table interpolator: directed table, then random phases.
`timescale 1ns / 1ps
module testbench;

    typedef struct packed {
        logic              op;
        logic [5:0]        row;
        logic [31:0]       rad;
        logic [3:0][31:0]  val;   // density, modulus, gravity, gradient
    } xfer_t;

    typedef struct packed {
        logic [3:0][31:0]  val;
        logic [5:0]        seg;
        logic [16:0]       frac;
        logic [2:0]        status;
    } profile_t;

    typedef struct {
        logic        do_cfg;
        logic [6:0]  cnt;
        xfer_t       x;
        logic        typed;
        profile_t    want;
    } step_t;

    localparam int SETTLE = 120;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [ptli_pkg::CNT_W-1:0]     cfg_wr_data = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [ptli_pkg::S_DATA_W-1:0]  s_tdata = '0;
    logic                           s_tuser = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [ptli_pkg::M_DATA_W-1:0]  m_tdata;
    logic [ptli_pkg::STATUS_W-1:0]  m_tuser;

    profile_table_linear_interp u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    // shadow of the block's table and count register
    logic [31:0]       node_rad [64];
    logic [3:0][31:0]  node_val [64];
    logic [6:0]        row_count = '0;
    profile_t          pending[$];
    int                errors = 0;
    bit                calm = 1'b0;
    step_t             steps[$];

    function automatic profile_t lookup(xfer_t x);
        profile_t r;
        int n;
        int k;
        longint num, den, hx, a, b;
        r = '0;
        if (x.op == ptli_pkg::OP_LOAD) begin
            node_rad[x.row] = x.rad;
            node_val[x.row] = x.val;
            r.status = ptli_pkg::STAT_LOADED;
            return r;
        end
        n = (row_count > 64) ? 64 : row_count;
        if (n < 2) begin
            r.status = ptli_pkg::STAT_NOT_READY;
        end else if (x.rad <= node_rad[0]) begin
            r.val = node_val[0];
            r.status = ptli_pkg::STAT_CLAMP_LO;
        end else if (x.rad >= node_rad[n-1]) begin
            r.val = node_val[n-1];
            r.seg = 6'(n - 1);
            r.status = ptli_pkg::STAT_CLAMP_HI;
        end else begin
            k = 0;
            for (int i = 1; i + 1 < n; i++)
                if (node_rad[i] <= x.rad) k = i;
            num = longint'({32'b0, x.rad - node_rad[k]});
            den = longint'({32'b0, node_rad[k+1] - node_rad[k]});
            hx = (den != 0) ? (num << 16) / den : 0;
            if (hx > 65536) hx = 65536;
            for (int j = 0; j < 4; j++) begin
                a = longint'($signed(node_val[k][j]));
                b = longint'($signed(node_val[k+1][j]));
                r.val[j] = 32'(a + (((b - a) * hx) >>> 16));
            end
            r.seg = 6'(k);
            r.frac = 17'(hx);
            r.status = ptli_pkg::STAT_INTERIOR;
        end
        return r;
    endfunction

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    // one input transfer; the prediction is queued at the accepting edge
    task automatic send(xfer_t x, logic typed = 1'b0, profile_t want = '0);
        int gap;
        profile_t got;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= x.op;
        s_tdata  <= {2'b0, x.val[3], x.val[2], x.val[1], x.val[0], x.rad, x.row};
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        got = lookup(x);
        pending.push_back(typed ? want : got);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_count(logic [6:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        row_count = v;
    endtask

    function automatic xfer_t mk(logic op, logic [5:0] row, logic [31:0] rad,
                                 logic [31:0] d, logic [31:0] m, logic [31:0] g,
                                 logic [31:0] gr);
        xfer_t x;
        x.op = op; x.row = row; x.rad = rad;
        x.val = {gr, g, m, d};
        return x;
    endfunction

    task automatic add(logic do_cfg, logic [6:0] cnt, xfer_t x,
                       logic typed = 1'b0, profile_t want = '0);
        step_t s;
        s.do_cfg = do_cfg; s.cnt = cnt; s.x = x; s.typed = typed; s.want = want;
        steps.push_back(s);
    endtask

    function automatic xfer_t rand_load(logic [5:0] row, logic [31:0] rad);
        return mk(ptli_pkg::OP_LOAD, row, rad, $urandom, $urandom, $urandom, $urandom);
    endfunction

    function automatic xfer_t rand_query();
        int n, k;
        logic [31:0] rad, span;
        n = (row_count > 64) ? 64 : row_count;
        case ($urandom_range(0, 9))
            0, 1: rad = $urandom;
            2:    rad = node_rad[$urandom_range(0, (n > 0) ? n - 1 : 0)];
            default: begin
                if (n >= 2) begin
                    k = $urandom_range(0, n - 2);
                    span = node_rad[k+1] - node_rad[k];
                    rad = node_rad[k] + ((span == 0) ? 0 : ($urandom % span));
                end else begin
                    rad = $urandom;
                end
            end
        endcase
        return mk(ptli_pkg::OP_QUERY, 6'($urandom), rad, $urandom, $urandom, $urandom,
                  $urandom);
    endfunction

    // result side
    initial begin
        profile_t got, want;
        int stall;
        wait (aresetn);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(negedge aclk);
            while (!m_tvalid) @(negedge aclk);
            got.val    = m_tdata[127:0];
            got.seg    = m_tdata[133:128];
            got.frac   = m_tdata[150:134];
            got.status = m_tuser;
            @(posedge aclk);
            if (pending.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none actual %h",
                         $realtime, got);
                errors++;
            end else begin
                want = pending.pop_front();
                for (int j = 0; j < 4; j++)
                    if (got.val[j] !== want.val[j]) begin
                        $display("%0t: value %0d expected %h actual %h", $realtime, j,
                                 want.val[j], got.val[j]);
                        errors++;
                    end
                if (got.seg !== want.seg) begin
                    $display("%0t: segment expected %0d actual %0d", $realtime,
                             want.seg, got.seg);
                    errors++;
                end
                if (got.frac !== want.frac) begin
                    $display("%0t: fraction expected %h actual %h", $realtime,
                             want.frac, got.frac);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $realtime,
                             want.status, got.status);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("profile_table_linear_interp verification failed");
        $finish;
    end

    initial begin
        profile_t w;
        int n;
        logic [31:0] r;
        int counts[8];

        counts = '{64, 127, 2, 0, 1, 3, 64, 17};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows
        w = '0; w.status = ptli_pkg::STAT_NOT_READY;
        add(1, 0, mk(ptli_pkg::OP_QUERY, 0, 32'd5, 0, 0, 0, 0), 1, w);
        w = '0; w.status = ptli_pkg::STAT_LOADED;
        add(0, 0, mk(ptli_pkg::OP_LOAD, 0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
            32'hFFFF_FFFF), 1, w);
        add(0, 0, mk(ptli_pkg::OP_LOAD, 1, 32'd1000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'hFFFF_FFFF, 0), 1, w);
        add(0, 0, mk(ptli_pkg::OP_LOAD, 2, 32'd2000, 32'h0001_0000, 32'hFFFF_0000,
            32'h1234_5678, 32'h0), 1, w);
        add(0, 0, mk(ptli_pkg::OP_LOAD, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000,
            32'h7FFF_FFFF), 1, w);
        add(0, 0, mk(ptli_pkg::OP_LOAD, 63, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
            32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, w);
        w = '0; w.status = ptli_pkg::STAT_NOT_READY;
        add(1, 1, mk(ptli_pkg::OP_QUERY, 0, 32'd1500, 0, 0, 0, 0), 1, w);
        w = '0; w.status = ptli_pkg::STAT_CLAMP_LO;
        w.val = {32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000};
        add(1, 4, mk(ptli_pkg::OP_QUERY, 0, 32'd0, 0, 0, 0, 0), 1, w);
        w = '0; w.status = ptli_pkg::STAT_CLAMP_HI; w.seg = 6'd3;
        w.val = {32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
        add(0, 0, mk(ptli_pkg::OP_QUERY, 63, 32'hFFFF_FFFF, 0, 0, 0, 0), 1, w);
        add(0, 0, mk(ptli_pkg::OP_QUERY, 0, 32'd1, 0, 0, 0, 0));
        add(0, 0, mk(ptli_pkg::OP_QUERY, 0, 32'd500, 0, 0, 0, 0));
        add(0, 0, mk(ptli_pkg::OP_QUERY, 0, 32'd999, 0, 0, 0, 0));
        add(0, 0, mk(ptli_pkg::OP_QUERY, 0, 32'd1000, 0, 0, 0, 0));
        add(0, 0, mk(ptli_pkg::OP_QUERY, 0, 32'd1999, 0, 0, 0, 0));
        add(0, 0, mk(ptli_pkg::OP_QUERY, 0, 32'hFFFF_FFFE, 0, 0, 0, 0));
        add(0, 0, mk(ptli_pkg::OP_QUERY, 0, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 32'hFFFF_FFFF));
        add(1, 2, mk(ptli_pkg::OP_QUERY, 0, 32'd333, 0, 0, 0, 0));
        add(0, 0, mk(ptli_pkg::OP_QUERY, 0, 32'd1000, 0, 0, 0, 0));

        foreach (steps[i]) begin
            if (steps[i].do_cfg) set_count(steps[i].cnt);
            send(steps[i].x, steps[i].typed, steps[i].want);
        end

        // random phases: fresh ascending table, then a query-heavy mix
        foreach (counts[p]) begin
            calm = (p % 3 == 2);
            set_count(7'(counts[p]));
            n = (row_count > 64) ? 64 : row_count;
            r = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 4096);
            for (int i = 0; i < n; i++) begin
                send(rand_load(6'(i), r));
                if ($urandom_range(0, 7) != 0)
                    r = r + ($urandom_range(0, 32'h01FF_FFFF) >> $urandom_range(0, 20));
            end
            // in phase p == 3, let everything land before the mix
            if (p == 3) drain();
            for (int i = 0; i < 20; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send(rand_load(6'($urandom), $urandom));
                else
                    send(rand_query());
            end
        end

        drain();
        if (errors == 0)
            $display("profile_table_linear_interp verification clean");
        else
            $display("profile_table_linear_interp verification failed");
        $finish;
    end

endmodule

[sim.f]
rtl/ptli_pkg.sv
rtl/ptli_datapath.sv
rtl/ptli_ctrl.sv
rtl/profile_table_linear_interp.sv
bench/testbench.sv
